[src/ctc_pkg.sv]
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and tables of the C token classifier
// Result word layout, queue entry type, character classes and keyword table.
// ----------------------------------------------------------------------------
package ctc_pkg;

  // Line and keyword geometry.
  localparam int MAX_LINE  = 128;
  localparam int KW_CHARS  = 8;
  localparam int NUM_KW    = 29;
  localparam int POS_W     = 7;
  localparam int LEN_W     = 8;
  localparam int KW_W      = 5;
  localparam int KW_LEN_W  = 4;

  // Depth of the queue between front and back.
  localparam int QDEPTH    = 4;
  localparam int QAW       = 2;

  // Token classes as they appear on the result word.
  typedef enum logic [2:0] {
    CLS_PUNCT     = 3'd0,
    CLS_OPER      = 3'd1,
    CLS_KEYWORD   = 3'd2,
    CLS_NUMBER    = 3'd3,
    CLS_IDENT     = 3'd4,
    CLS_BAD_IDENT = 3'd5
  } tok_class_e;

  // One result word.
  typedef struct packed {
    logic             last;
    tok_class_e       cls;
    logic [KW_W-1:0]  kw;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [7:0]       pchar;
  } result_t;

  // One queue entry: an optional closed token and an optional punctuator.
  typedef struct packed {
    logic    has_tok;
    logic    has_pun;
    result_t tok;
    result_t pun;
  } entry_t;

  // Queue status seen by the back and by the input handshake.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [KW_CHARS-1:0][7:0] prefix_t;

  // The 18 token separators.
  function automatic logic is_punct(input logic [7:0] c);
    return c inside {8'h20, "+", "-", "*", "/", ",", ";", ">", "<", "=",
                     "(", ")", "[", "]", "{", "}", "&", "|"};
  endfunction

  // Separators that are also operators.
  function automatic logic is_oper(input logic [7:0] c);
    return c inside {"+", "-", "*", "/", ">", "<", "=", "|", "&"};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Keyword text, right aligned, first character in the highest used byte.
  function automatic logic [KW_CHARS*8-1:0] kw_text(input int k);
    logic [KW_CHARS*8-1:0] t;
    case (k)
      0:       t = "if";
      1:       t = "else";
      2:       t = "while";
      3:       t = "do";
      4:       t = "break";
      5:       t = "continue";
      6:       t = "int";
      7:       t = "double";
      8:       t = "float";
      9:       t = "return";
      10:      t = "char";
      11:      t = "case";
      12:      t = "long";
      13:      t = "short";
      14:      t = "typedef";
      15:      t = "switch";
      16:      t = "unsigned";
      17:      t = "void";
      18:      t = "static";
      19:      t = "struct";
      20:      t = "sizeof";
      21:      t = "volatile";
      22:      t = "enum";
      23:      t = "const";
      24:      t = "union";
      25:      t = "extern";
      26:      t = "bool";
      27:      t = "cout";
      28:      t = "str";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [KW_LEN_W-1:0] kw_len(input int k);
    logic [KW_LEN_W-1:0] l;
    case (k)
      0, 3:                    l = 4'd2;
      6, 28:                   l = 4'd3;
      1, 10, 11, 12, 17, 22,
      26, 27:                  l = 4'd4;
      2, 4, 8, 13, 23, 24:     l = 4'd5;
      7, 9, 15, 18, 19, 20,
      25:                      l = 4'd6;
      14:                      l = 4'd7;
      5, 16, 21:               l = 4'd8;
      default:                 l = 4'd0;
    endcase
    return l;
  endfunction

  // Keyword search: {found, index}; the lowest matching index wins.
  function automatic logic [KW_W:0] kw_lookup(input prefix_t pre,
                                              input logic [LEN_W-1:0] len);
    logic [KW_W:0]         res;
    logic [KW_CHARS*8-1:0] t;
    logic [KW_LEN_W-1:0]   l;
    logic                  same;
    res = '0;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      l = kw_len(k);
      // Left align the text so character i sits at a fixed byte.
      t = kw_text(k) << ((KW_CHARS - int'(l)) * 8);
      same = (len == LEN_W'(l));
      for (int i = 0; i < KW_CHARS; i++) begin
        if ((i < int'(l)) && (pre[i] != t[(KW_CHARS-1-i)*8 +: 8])) begin
          same = 1'b0;
        end
      end
      if (same) begin
        res = {1'b1, KW_W'(k)};
      end
    end
    return res;
  endfunction

endpackage

[src/ctc_front.sv]
// ----------------------------------------------------------------------------
// ctc_front: token tracker and classifier
// Takes a byte a cycle if accept_i, tracks the pending token, pushes entries.
// ----------------------------------------------------------------------------
module ctc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        ch_i,
  input  logic              line_end_i,
  output logic              push_o,
  output ctc_pkg::entry_t   entry_o
);
  import ctc_pkg::*;

  prefix_t          prefix_q, prefix_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [POS_W-1:0] start_q, start_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             all_dig_q, all_dig_d;
  logic             first_dig_q, first_dig_d;

  logic             punct;
  logic             digit;
  logic [KW_W:0]    kw_hit;
  logic [POS_W-1:0] pos_adv;
  tok_class_e       tok_cls;

  assign punct = is_punct(ch_i);
  assign digit = is_digit(ch_i);
  assign kw_hit = kw_lookup(prefix_q, len_q);
  assign pos_adv = (pos_q < POS_W'(MAX_LINE - 1)) ? pos_q + 1'b1 : pos_q;

  // Classify the pending token.
  always_comb begin
    if (kw_hit[KW_W]) begin
      tok_cls = CLS_KEYWORD;
    end else if (all_dig_q) begin
      tok_cls = CLS_NUMBER;
    end else if (!first_dig_q) begin
      tok_cls = CLS_IDENT;
    end else begin
      tok_cls = CLS_BAD_IDENT;
    end
  end

  // Build the queue entry for this word.
  always_comb begin
    entry_o.has_tok   = len_q != '0;
    entry_o.has_pun   = !line_end_i;
    entry_o.tok.last  = line_end_i;
    entry_o.tok.cls   = tok_cls;
    entry_o.tok.kw    = kw_hit[KW_W] ? kw_hit[KW_W-1:0] : '0;
    entry_o.tok.start = start_q;
    entry_o.tok.len   = len_q;
    entry_o.tok.pchar = '0;
    entry_o.pun.last  = 1'b1;
    entry_o.pun.cls   = is_oper(ch_i) ? CLS_OPER : CLS_PUNCT;
    entry_o.pun.kw    = '0;
    entry_o.pun.start = pos_q;
    entry_o.pun.len   = LEN_W'(1);
    entry_o.pun.pchar = ch_i;
    push_o = accept_i && (line_end_i ? (len_q != '0) : punct);
  end

  // Pending token state update.
  always_comb begin
    prefix_d    = prefix_q;
    len_d       = len_q;
    start_d     = start_q;
    pos_d       = pos_q;
    all_dig_d   = all_dig_q;
    first_dig_d = first_dig_q;
    if (accept_i) begin
      if (line_end_i || punct) begin
        len_d       = '0;
        start_d     = '0;
        all_dig_d   = 1'b1;
        first_dig_d = 1'b0;
        pos_d       = line_end_i ? '0 : pos_adv;
      end else begin
        if (len_q == '0) begin
          start_d     = pos_q;
          all_dig_d   = digit;
          first_dig_d = digit;
        end else if (!digit) begin
          all_dig_d = 1'b0;
        end
        if (len_q < LEN_W'(KW_CHARS)) begin
          prefix_d[len_q[$clog2(KW_CHARS)-1:0]] = ch_i;
        end
        if (len_q < LEN_W'(MAX_LINE)) begin
          len_d = len_q + 1'b1;
        end
        pos_d = pos_adv;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      start_q     <= '0;
      pos_q       <= '0;
      all_dig_q   <= 1'b1;
      first_dig_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      start_q     <= start_d;
      pos_q       <= pos_d;
      all_dig_q   <= all_dig_d;
      first_dig_q <= first_dig_d;
    end
  end

  // Prefix bytes are only read below the pending length.
  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
  end

endmodule

[src/ctc_queue.sv]
// ----------------------------------------------------------------------------
// ctc_queue: entry queue between front and back
// A small register FIFO that lets each side stall on its own.
// ----------------------------------------------------------------------------
module ctc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ctc_pkg::entry_t     entry_i,
  input  logic                pop_i,
  output ctc_pkg::entry_t     head_o,
  output ctc_pkg::q_status_t  status_o
);
  import ctc_pkg::*;

  entry_t         mem_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QAW:0]   count_q;

  assign status_o.full  = count_q == (QAW+1)'(QDEPTH);
  assign status_o.empty = count_q == '0;
  assign head_o = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

[src/ctc_back.sv]
// ----------------------------------------------------------------------------
// ctc_back: result sequencer
// Pops queue entries and delivers one or two result words through an
// output register, holding a second word until the first is taken.
// ----------------------------------------------------------------------------
module ctc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctc_pkg::entry_t     head_i,
  input  ctc_pkg::q_status_t  status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctc_pkg::result_t    out_o
);
  import ctc_pkg::*;

  result_t out_q, out_d;
  result_t pend_q, pend_d;
  logic    out_valid_q, out_valid_d;
  logic    pend_valid_q, pend_valid_d;
  logic    out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = out_free && !pend_valid_q && !status_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Load the output register from the held word or the queue head.
  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pend_valid_d = pend_valid_q;
    if (out_free) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end else if (!status_i.empty) begin
        out_valid_d = 1'b1;
        if (head_i.has_tok) begin
          out_d        = head_i.tok;
          pend_d       = head_i.pun;
          pend_valid_d = head_i.has_pun;
        end else begin
          out_d = head_i.pun;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

endmodule

[src/c_token_classifier_core.sv]
// ----------------------------------------------------------------------------
// c_token_classifier_core: lexical classifier for one line of C-like text
// Splits a byte stream into tokens and punctuators and classifies each.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one word per cycle: a character in tdata, or an
//   end-of-line marker with tlast high (tdata is then ignored). The master
//   channel delivers result words; tlast marks the last result caused by
//   one input word. A punctuator that closes a token yields two results,
//   the token first; an end of line yields the pending token, if any.
//   An accepted input word reaches the master side through the queue storage
//   and then the output register. Input words are taken every cycle while the
//   four-entry queue has room; the back end delivers one result per cycle
//   while the receiver is ready, so sustained throughput is one input word per
//   cycle, except that a punctuator that closes a token takes the single output
//   register for two results. When the receiver stalls, results wait in the
//   output register and the queue, and tready drops once the queue is full.
//   Reset clears the pending token, the line position and all queued results.
// ----------------------------------------------------------------------------
module c_token_classifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,   // line_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] token_class, [7:3] keyword_index, [14:8] start_pos,
  // [22:15] token_length, [30:23] punct_char, [31] zero
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // last_of_run
);
  import ctc_pkg::*;

  logic      accept;
  logic      push;
  logic      pop;
  entry_t    entry;
  entry_t    head;
  q_status_t status;
  result_t   res;

  assign s_axis_tready_o = !status.full;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  ctc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ch_i       (s_axis_tdata_i),
    .line_end_i (s_axis_tlast_i),
    .push_o     (push),
    .entry_o    (entry)
  );

  ctc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  ctc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  // Pack the result word.
  assign m_axis_tdata_o = {1'b0, res.pchar, res.len, res.start, res.kw, res.cls};
  assign m_axis_tlast_o = res.last;

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !status.full)
    else $error("queue written while full");

  // The queue is never read while empty.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !status.empty)
    else $error("queue read while empty");

  // The second word of a pair follows right after the first is taken.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("second result of a pair missing");

  // Only keyword results carry a nonzero keyword index.
  a_field_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res.cls != CLS_KEYWORD)) |-> (res.kw == '0))
    else $error("keyword index set on a non-keyword result");

endmodule
